// ===== rtl/core/sdrv_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrv_pkg: shared types and constants of the three-phase sine drive
// Item formats, command classes, status codes, register indexes and the
// elaboration-time generator of the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package sdrv_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic       outputs_enabled;
    logic       enable_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               duties_valid;
    logic [15:0]        duty_a;
    logic [15:0]        duty_b;
    logic [15:0]        duty_c;
    logic               cut_request;
    logic               running;
    logic signed [31:0] present_step;
    logic [31:0]        angle;
  } out_item_t;

  typedef struct packed {
    logic [9:0]         amplitude_pm;
    logic signed [31:0] target_step;
    logic [23:0]        ramp_step;
    logic [30:0]        max_step;
    logic [15:0]        period_top;
  } cfg_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       outs_on;
    logic       en_ok;
    logic       over_limit;
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOP = 3'd4;

  localparam logic [15:0] PERIOD_TOP_RESET = 16'd1023;
  localparam logic [9:0]  MAX_AMP_PM       = 10'd57;

  localparam logic [31:0] OFFSET_B = 32'h5555_5555;
  localparam logic [31:0] OFFSET_C = 32'hAAAA_AAAB;

  localparam logic [1:0]  LAST_PHASE = 2'd2;

  localparam logic signed [27:0] N_BIAS      = 28'sd16384000;
  localparam logic [30:0]        RECIP_1000  = 31'd1099511628;
  localparam logic [15:0]        DUTY_MAX    = 16'hFFFF;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Entry i of a quarter wave with 2^abits intervals, Q0.15, from a Q30 series.
  function automatic logic [14:0] cos_entry(input int unsigned i, input int unsigned abits);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint res;
    x    = (HALF_PI_Q30 * longint'(i)) >>> abits;
    x2   = (x * x) >>> 30;
    term = 64'sd1 <<< 30;
    sum  = term;
    term = ((term * x2) >>> 30) / 2;   sum = sum - term;
    term = ((term * x2) >>> 30) / 12;  sum = sum + term;
    term = ((term * x2) >>> 30) / 30;  sum = sum - term;
    term = ((term * x2) >>> 30) / 56;  sum = sum + term;
    term = ((term * x2) >>> 30) / 90;  sum = sum - term;
    term = ((term * x2) >>> 30) / 132; sum = sum + term;
    term = ((term * x2) >>> 30) / 182; sum = sum - term;
    term = ((term * x2) >>> 30) / 240; sum = sum + term;
    term = ((term * x2) >>> 30) / 306; sum = sum - term;
    term = ((term * x2) >>> 30) / 380; sum = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    res = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    return res[14:0];
  endfunction

endpackage

// ===== rtl/core/sdrv_front.sv =====
// ----------------------------------------------------------------------------
// sdrv_front: item intake and classification
// Decodes the action of each accepted item, checks the start limits and
// pushes one command into the queue toward the execution side.
// ----------------------------------------------------------------------------
module sdrv_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  sdrv_pkg::in_item_t in_item,
  input  sdrv_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              push_valid,
  output sdrv_pkg::cmd_t    push_cmd
);

  logic [31:0] target_mag;
  logic        over_limit;
  logic [1:0]  kind;

  assign target_mag = cfg.target_step[31] ? (~cfg.target_step + 32'd1) : cfg.target_step;
  assign over_limit = (cfg.amplitude_pm > sdrv_pkg::MAX_AMP_PM) ||
                      (target_mag > {1'b0, cfg.max_step});

  always_comb begin
    unique case (in_item.action)
      sdrv_pkg::ACT_TICK:  kind = sdrv_pkg::CMD_TICK;
      sdrv_pkg::ACT_START: kind = sdrv_pkg::CMD_START;
      sdrv_pkg::ACT_STOP:  kind = sdrv_pkg::CMD_STOP;
      default:             kind = sdrv_pkg::CMD_NOP;
    endcase
  end

  assign in_stall            = q_full;
  assign push_valid          = in_valid && !q_full;
  assign push_cmd.kind       = kind;
  assign push_cmd.outs_on    = in_item.outputs_enabled;
  assign push_cmd.en_ok      = in_item.enable_ok;
  assign push_cmd.over_limit = over_limit;

endmodule

// ===== rtl/core/sdrv_queue.sv =====
// ----------------------------------------------------------------------------
// sdrv_queue: short command queue
// Two-entry first-in first-out store between intake and execution.
// ----------------------------------------------------------------------------
module sdrv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sdrv_pkg::cmd_t push_data,
  input  logic           pop,
  output sdrv_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  sdrv_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full     = (count_r == (PTR_W+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sdrv_back.sv =====
// ----------------------------------------------------------------------------
// sdrv_back: command execution and duty computation
// Holds the drive state, applies each command, and computes the three duties
// one phase after another through a cosine table and a multiply pipeline.
// ----------------------------------------------------------------------------
module sdrv_back #(
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdrv_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  sdrv_pkg::cmd_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sdrv_pkg::out_item_t out_item
);

  localparam int unsigned QUARTER = 1 << SINE_ADDR_BITS;
  localparam int unsigned ADDR_W  = SINE_ADDR_BITS + 1;
  localparam int unsigned IDX_W   = SINE_ADDR_BITS + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADV   = 4'd1;
  localparam logic [3:0] S_ROM   = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_BIAS  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_MUL3  = 4'd6;
  localparam logic [3:0] S_STORE = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [14:0] cos_rom [QUARTER+1];

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
    assign cos_rom[gi] = sdrv_pkg::cos_entry(gi, SINE_ADDR_BITS);
  end

  logic [3:0]          state_r;
  logic                active_r;
  logic signed [31:0]  speed_r;
  logic [31:0]         phase_r;
  logic                out_valid_r;
  sdrv_pkg::out_item_t out_item_r;

  logic [1:0]          status_r;
  logic                dv_r;
  logic                cut_r;
  logic [1:0]          ph_r;
  logic [15:0]         duty_r [3];

  logic [14:0]         rom_q_r;
  logic                neg_r;
  logic signed [26:0]  amp_c_r;
  logic [25:0]         n_r;
  logic [42:0]         prod_r;
  logic [58:0]         quot_r;

  logic [31:0]         ph_offset;
  logic [31:0]         ph_angle;
  logic [IDX_W-1:0]    ang_idx;
  logic [1:0]          quad;
  logic [ADDR_W-1:0]   low_idx;
  logic [ADDR_W-1:0]   rom_addr;
  logic signed [15:0]  cos_val;
  logic signed [27:0]  biased;
  logic [16:0]         scale;
  logic [18:0]         quot;
  logic [15:0]         duty_sat;

  logic signed [33:0]  s_ext;
  logic signed [33:0]  t_ext;
  logic signed [33:0]  r_ext;
  logic signed [33:0]  up_sum;
  logic signed [33:0]  dn_sum;
  logic signed [31:0]  ramp_step_nxt;
  logic                out_free;

  always_comb begin
    case (ph_r)
      2'd0:    ph_offset = '0;
      2'd1:    ph_offset = sdrv_pkg::OFFSET_B;
      default: ph_offset = sdrv_pkg::OFFSET_C;
    endcase
  end

  assign ph_angle = phase_r - ph_offset;
  assign ang_idx  = ph_angle[31 -: IDX_W];
  assign quad     = ang_idx[IDX_W-1 -: 2];
  assign low_idx  = {1'b0, ang_idx[SINE_ADDR_BITS-1:0]};
  assign rom_addr = quad[0] ? (ADDR_W'(QUARTER) - low_idx) : low_idx;

  always_ff @(posedge clk) begin
    rom_q_r <= cos_rom[rom_addr];
    neg_r   <= quad[1] ^ quad[0];
  end

  assign cos_val  = neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
  assign biased   = 28'(amp_c_r) + sdrv_pkg::N_BIAS;
  assign scale    = {1'b0, cfg.period_top} + 17'd1;
  assign quot     = quot_r[58:40];
  assign duty_sat = (quot > 19'(sdrv_pkg::DUTY_MAX)) ? sdrv_pkg::DUTY_MAX : quot[15:0];

  assign s_ext  = 34'(speed_r);
  assign t_ext  = 34'(cfg.target_step);
  assign r_ext  = $signed({10'd0, cfg.ramp_step});
  assign up_sum = s_ext + r_ext;
  assign dn_sum = s_ext - r_ext;

  always_comb begin
    if (speed_r < cfg.target_step) begin
      ramp_step_nxt = (up_sum > t_ext) ? cfg.target_step : up_sum[31:0];
    end else if (speed_r > cfg.target_step) begin
      ramp_step_nxt = (dn_sum < t_ext) ? cfg.target_step : dn_sum[31:0];
    end else begin
      ramp_step_nxt = speed_r;
    end
  end

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      speed_r     <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cut_r <= (q_data.kind == sdrv_pkg::CMD_STOP);
            ph_r  <= '0;
            unique case (q_data.kind)
              sdrv_pkg::CMD_START: begin
                if (q_data.over_limit) begin
                  status_r <= sdrv_pkg::ST_OVER;
                  dv_r     <= 1'b0;
                  state_r  <= S_DONE;
                end else if (q_data.outs_on) begin
                  status_r <= sdrv_pkg::ST_BUSY;
                  dv_r     <= 1'b0;
                  state_r  <= S_DONE;
                end else begin
                  speed_r <= '0;
                  phase_r <= '0;
                  dv_r    <= 1'b1;
                  state_r <= S_ROM;
                  if (q_data.en_ok) begin
                    active_r <= 1'b1;
                    status_r <= sdrv_pkg::ST_OK;
                  end else begin
                    status_r <= sdrv_pkg::ST_FAIL;
                  end
                end
              end
              sdrv_pkg::CMD_STOP: begin
                active_r <= 1'b0;
                status_r <= sdrv_pkg::ST_OK;
                dv_r     <= 1'b0;
                state_r  <= S_DONE;
              end
              sdrv_pkg::CMD_TICK: begin
                status_r <= sdrv_pkg::ST_OK;
                if (active_r && q_data.outs_on) begin
                  speed_r <= ramp_step_nxt;
                  dv_r    <= 1'b1;
                  state_r <= S_ADV;
                end else begin
                  active_r <= 1'b0;
                  dv_r     <= 1'b0;
                  state_r  <= S_DONE;
                end
              end
              default: begin
                status_r <= sdrv_pkg::ST_OK;
                dv_r     <= 1'b0;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_ADV: begin
          phase_r <= phase_r + speed_r;
          state_r <= S_ROM;
        end
        S_ROM: begin
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          amp_c_r <= $signed({1'b0, cfg.amplitude_pm}) * cos_val;
          state_r <= S_BIAS;
        end
        S_BIAS: begin
          n_r     <= biased[27] ? '0 : biased[25:0];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= n_r * scale;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          quot_r  <= prod_r[42:15] * sdrv_pkg::RECIP_1000;
          state_r <= S_STORE;
        end
        S_STORE: begin
          duty_r[ph_r] <= duty_sat;
          if (ph_r == sdrv_pkg::LAST_PHASE) begin
            state_r <= S_DONE;
          end else begin
            ph_r    <= ph_r + 2'd1;
            state_r <= S_ROM;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_item_r.status       <= status_r;
            out_item_r.duties_valid <= dv_r;
            out_item_r.duty_a       <= dv_r ? duty_r[0] : '0;
            out_item_r.duty_b       <= dv_r ? duty_r[1] : '0;
            out_item_r.duty_c       <= dv_r ? duty_r[2] : '0;
            out_item_r.cut_request  <= cut_r;
            out_item_r.running      <= active_r;
            out_item_r.present_step <= speed_r;
            out_item_r.angle        <= phase_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/open_loop_three_phase_sine_drive_core.sv =====
// ----------------------------------------------------------------------------
// open_loop_three_phase_sine_drive_core: open-loop sinusoidal 3-phase drive
// Items on the in_ channel are start, stop or control-tick requests; each
// produces exactly one result item on the out_ channel with status, the
// three PWM compare values, the running flag, the ramped step and the angle.
// Both channels are valid/stall: an item moves when valid is high and stall
// is low. Registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the drive is idle, the block does not enforce it.
// An accepted item enters a two-entry queue; the execution side takes it when
// idle. A tick that presents duties passes S_ADV, then, for each of the three
// phases in turn, S_ROM, S_MUL1, S_BIAS, S_MUL2, S_MUL3 and S_STORE, then S_DONE;
// a start that presents duties skips S_ADV, and other items go to S_DONE.
// The execution side takes no new item before it is through with the last,
// as the single multiply pipeline works out the three phases one after another.
// A result waiting under out_stall holds; up to three further items are
// still accepted, one worked on and two in the queue. Synchronous reset
// clears the drive state, the queue and the output valid, and loads the
// register reset values.
// ----------------------------------------------------------------------------
module open_loop_three_phase_sine_drive_core #(
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sdrv_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sdrv_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [sdrv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdrv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sdrv_pkg::cfg_t cfg_r;
  sdrv_pkg::cmd_t push_cmd;
  sdrv_pkg::cmd_t pop_cmd;
  logic           push_valid;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude_pm <= '0;
      cfg_r.target_step  <= '0;
      cfg_r.ramp_step    <= '0;
      cfg_r.max_step     <= '0;
      cfg_r.period_top   <= sdrv_pkg::PERIOD_TOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdrv_pkg::REG_AMPLITUDE:  cfg_r.amplitude_pm <= cfg_wdata[9:0];
        sdrv_pkg::REG_TARGET:     cfg_r.target_step  <= cfg_wdata;
        sdrv_pkg::REG_RAMP:       cfg_r.ramp_step    <= cfg_wdata[23:0];
        sdrv_pkg::REG_MAX_STEP:   cfg_r.max_step     <= cfg_wdata[30:0];
        sdrv_pkg::REG_PERIOD_TOP: cfg_r.period_top   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  sdrv_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  sdrv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  sdrv_back #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_zero_duties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.duties_valid |->
      out_item.duty_a == '0 && out_item.duty_b == '0 && out_item.duty_c == '0)
    else $error("Duties are nonzero on a result without new duties.");

  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.cut_request |->
      !out_item.running && out_item.status == sdrv_pkg::ST_OK)
    else $error("A stop result reports a running drive or an error.");

  a_rejected_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == sdrv_pkg::ST_OVER ||
                  out_item.status == sdrv_pkg::ST_BUSY) |->
      !out_item.duties_valid)
    else $error("A rejected start presents duties.");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("A result is presented right after reset.");

endmodule
